[design/ccx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccx_pkg
// Shared types and constants for the ChaCha20 stream XOR block.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned QR_STEPS      = DOUBLE_ROUNDS * 8;
  localparam int unsigned QR_CNT_W      = $clog2(QR_STEPS + 1);

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE0 = 3'd4;
  localparam logic [2:0] REG_NONCE1 = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;       // load initial state
    logic qr_step;    // run one quarter round
    logic finish;     // feed-forward add into keystream
    logic [2:0] qr_sel;
  } ccx_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

[design/ccx_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccx_ctrl
// Sequencer: byte handshake, block position, counter and round schedule.
// ----------------------------------------------------------------------------
module ccx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_first,
  output logic                 in_ready,
  input  logic                 out_busy,
  output logic                 out_load,
  output logic [5:0]           rd_pos,
  output logic [31:0]          ctr,
  output ccx_pkg::ccx_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_ROUND, S_FIN} state_t;

  state_t state;
  logic [5:0] position;
  logic [31:0] block_counter;
  logic [ccx_pkg::QR_CNT_W-1:0] qr_cnt;
  logic [5:0] pend_pos;

  logic take;
  logic [5:0] eff_pos;
  assign in_ready = (state == S_IDLE) && !out_busy;
  assign take = in_valid && in_ready;
  assign eff_pos = in_first ? 6'd0 : position;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_INIT);
    cmd.qr_step = (state == S_ROUND);
    cmd.finish = (state == S_FIN);
    cmd.qr_sel = qr_cnt[2:0];
  end

  assign out_load = (take && eff_pos != 6'd0) || (state == S_FIN);
  assign rd_pos = (state == S_FIN) ? pend_pos : eff_pos;
  assign ctr = block_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      position <= '0;
      block_counter <= 32'd1;
      qr_cnt <= '0;
      pend_pos <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (in_first) block_counter <= 32'd1;
            pend_pos <= eff_pos;
            position <= eff_pos + 6'd1;
            if (eff_pos == 6'd0) state <= S_INIT;
          end
        end
        S_INIT: begin
          qr_cnt <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          qr_cnt <= qr_cnt + 1'b1;
          if (qr_cnt == ccx_pkg::QR_CNT_W'(ccx_pkg::QR_STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          block_counter <= block_counter + 32'd1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/ccx_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccx_datapath
// Working state and shared quarter-round unit; the feed-forward add leaves the
// keystream block in the working state.
// ----------------------------------------------------------------------------
module ccx_datapath (
  input  logic               clk,
  input  logic [255:0]       key,
  input  logic [95:0]        nonce,
  input  logic [31:0]        ctr,
  input  ccx_pkg::ccx_cmd_t  cmd,
  input  logic [5:0]         rd_pos,
  output logic [7:0]         ks_byte
);

  logic [31:0] work [16];
  logic [31:0] init [16];

  always_comb begin
    init[0] = ccx_pkg::SIGMA_0;
    init[1] = ccx_pkg::SIGMA_1;
    init[2] = ccx_pkg::SIGMA_2;
    init[3] = ccx_pkg::SIGMA_3;
    for (int i = 0; i < 8; i++) init[4 + i] = key[32*i +: 32];
    init[12] = ctr;
    init[13] = nonce[31:0];
    init[14] = nonce[63:32];
    init[15] = nonce[95:64];
  end

  // column/diagonal index selection
  logic [3:0] ia, ib, ic, id;
  always_comb begin
    case (cmd.qr_sel)
      3'd0: {ia, ib, ic, id} = {4'd0, 4'd4, 4'd8,  4'd12};
      3'd1: {ia, ib, ic, id} = {4'd1, 4'd5, 4'd9,  4'd13};
      3'd2: {ia, ib, ic, id} = {4'd2, 4'd6, 4'd10, 4'd14};
      3'd3: {ia, ib, ic, id} = {4'd3, 4'd7, 4'd11, 4'd15};
      3'd4: {ia, ib, ic, id} = {4'd0, 4'd5, 4'd10, 4'd15};
      3'd5: {ia, ib, ic, id} = {4'd1, 4'd6, 4'd11, 4'd12};
      3'd6: {ia, ib, ic, id} = {4'd2, 4'd7, 4'd8,  4'd13};
      default: {ia, ib, ic, id} = {4'd3, 4'd4, 4'd9,  4'd14};
    endcase
  end

  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  always_comb begin
    a0 = work[ia] + work[ib];
    d0 = ccx_pkg::rotl(work[id] ^ a0, 16);
    c0 = work[ic] + d0;
    b0 = ccx_pkg::rotl(work[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = ccx_pkg::rotl(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = ccx_pkg::rotl(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) work[i] <= init[i];
    end else if (cmd.qr_step) begin
      work[ia] <= a2;
      work[ib] <= b2;
      work[ic] <= c2;
      work[id] <= d2;
    end else if (cmd.finish) begin
      for (int i = 0; i < 16; i++) work[i] <= work[i] + init[i];
    end
  end

  // finish adds in place at the edge where rd_pos reads: bypass the fresh word
  logic [31:0] ks_word;
  assign ks_word = cmd.finish ? work[rd_pos[5:2]] + init[rd_pos[5:2]] : work[rd_pos[5:2]];
  assign ks_byte = ks_word[8*rd_pos[1:0] +: 8];

endmodule

[design/chacha20_stream_xor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 (IETF) keystream XOR over a byte stream.
// ----------------------------------------------------------------------------
// channel  dir  tdata            tuser
// s_axis   in   [7:0] data_in    [0] first_byte   (tlast = last_byte)
// m_axis   out  [7:0] data_out   -                (tlast = last_out)
// apb      cfg  6 regs x 64 bit at 8*i (NONCE1 keeps only the low 32 bit)
//
// Position 0 (or first flag) runs one shared quarter-round unit: load, 80
// quarter rounds, feed-forward add, then the item lands. No byte is taken
// while a block is generated. Reset: counter 1, position 0, regs 0.
// Output register holds one item; input stalls while it is full and unread.
// ----------------------------------------------------------------------------
module chacha20_stream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_out
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_word_0, key_word_1, key_word_2, key_word_3, nonce_low;
  logic [31:0] nonce_high;
  logic [2:0]  reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0; key_word_1 <= '0; key_word_2 <= '0; key_word_3 <= '0;
      nonce_low <= '0; nonce_high <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ccx_pkg::REG_KEY0:   key_word_0 <= pwdata;
        ccx_pkg::REG_KEY1:   key_word_1 <= pwdata;
        ccx_pkg::REG_KEY2:   key_word_2 <= pwdata;
        ccx_pkg::REG_KEY3:   key_word_3 <= pwdata;
        ccx_pkg::REG_NONCE0: nonce_low <= pwdata;
        ccx_pkg::REG_NONCE1: nonce_high <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ccx_pkg::REG_KEY0:   prdata = key_word_0;
      ccx_pkg::REG_KEY1:   prdata = key_word_1;
      ccx_pkg::REG_KEY2:   prdata = key_word_2;
      ccx_pkg::REG_KEY3:   prdata = key_word_3;
      ccx_pkg::REG_NONCE0: prdata = nonce_low;
      ccx_pkg::REG_NONCE1: prdata = {32'd0, nonce_high};
      default:             prdata = '0;
    endcase
  end

  ccx_pkg::ccx_cmd_t cmd;
  logic out_load, out_busy;
  logic [5:0] rd_pos;
  logic [31:0] ctr;
  logic [7:0] ks_byte;
  logic [7:0] hold_data;
  logic hold_last;

  assign out_busy = m_axis_tvalid && !m_axis_tready;

  ccx_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_first(s_axis_tuser), .in_ready(s_axis_tready),
    .out_busy(out_busy), .out_load(out_load), .rd_pos(rd_pos), .ctr(ctr), .cmd(cmd)
  );

  ccx_datapath u_dp (
    .clk(clk),
    .key({key_word_3, key_word_2, key_word_1, key_word_0}),
    .nonce({nonce_high, nonce_low}),
    .ctr(ctr), .cmd(cmd), .rd_pos(rd_pos), .ks_byte(ks_byte)
  );

  // item captured on acceptance and held while its block is generated
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_data <= s_axis_tdata;
      hold_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.finish) begin
        m_axis_tdata <= hold_data ^ ks_byte;
        m_axis_tlast <= hold_last;
      end else begin
        m_axis_tdata <= s_axis_tdata ^ ks_byte;
        m_axis_tlast <= s_axis_tlast;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_busy |-> !out_load) else $error("result overwritten while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.qr_step || cmd.load) |-> !s_axis_tready) else $error("accept during block");
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_load) else $error("finish without output");

endmodule
